### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is held.
`define HOTP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, also live during reset.
`define HOTP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/hotp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hotp_pkg
// Types and constants for the HMAC-SHA1 one-time password generator.
// ----------------------------------------------------------------------------
package hotp_pkg;

  localparam int unsigned KeyWords   = 8;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CounterW   = 64;
  localparam int unsigned CodeW      = 20;
  localparam int unsigned TruncW     = 31;
  localparam int unsigned BlockW     = 512;
  localparam int unsigned DigestW    = 160;

  // Quotient by one million: drop six bits (divide by 64), then multiply by
  // the rounded-up reciprocal of 15625 and shift; exact for 25-bit inputs
  localparam int unsigned QuoW       = 12;
  localparam int unsigned RecipInW   = 25;
  localparam int unsigned RecipW     = 26;
  localparam int unsigned ProdW      = RecipInW + RecipW;
  localparam int unsigned RecipShift = 39;
  localparam logic [RecipW-1:0] RECIP_15625 = 26'd35184373;

  localparam logic [7:0]  IPAD_BYTE   = 8'h36;
  localparam logic [7:0]  OPAD_BYTE   = 8'h5C;
  localparam logic [7:0]  OFFSET_MASK = 8'h0F;
  localparam logic [7:0]  TOP_MASK    = 8'h7F;
  localparam logic [TruncW-1:0] HOTP_MODULUS = 31'd1000000;

  // Message lengths in bits, pad block included.
  localparam logic [63:0] INNER_LEN_BITS = 64'd576;
  localparam logic [63:0] OUTER_LEN_BITS = 64'd672;

  localparam logic [DigestW-1:0] SHA1_IV =
    {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};

  localparam logic [31:0] K_ROUND0 = 32'h5A827999;
  localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

  // Which compression is running.
  localparam logic [1:0] BLK_IPAD  = 2'd0;
  localparam logic [1:0] BLK_INNER = 2'd1;
  localparam logic [1:0] BLK_OPAD  = 2'd2;
  localparam logic [1:0] BLK_OUTER = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_HASH,
    ST_TRUNC,
    ST_MOD,
    ST_MOD_WAIT,
    ST_OUT
  } hotp_state_e;

  // Handshake between sequencer and a shared unit.
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage

### rtl/hotp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hotp interfaces
// Counter input, code output and key write channels.
// ----------------------------------------------------------------------------
interface hotp_in_if import hotp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CounterW-1:0] moving_counter;
  modport source (output valid, output moving_counter, input ready);
  modport sink   (input valid, input moving_counter, output ready);
endinterface

interface hotp_out_if import hotp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CodeW-1:0]  otp_code;
  logic [TruncW-1:0] truncated_value;
  modport source (output valid, output otp_code, output truncated_value, input ready);
  modport sink   (input valid, input otp_code, input truncated_value, output ready);
endinterface

interface hotp_cfg_if import hotp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/hotp_sha1_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hotp_sha1_core
// One SHA-1 compression, one round per cycle, rolling 16-word schedule.
// ----------------------------------------------------------------------------
module hotp_sha1_core import hotp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  unit_req_t          req_i,
  input  logic [DigestW-1:0] chain_i,
  input  logic [BlockW-1:0]  block_i,
  output unit_rsp_t          rsp_o,
  output logic [DigestW-1:0] digest_o
);

  logic        busy_q, fin_q, done_q;
  logic [6:0]  rnd_q;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] h_q [5];
  logic [31:0] w_q [16];
  logic [31:0] f_rnd, k_rnd, t_rnd, w_new;

  // Round function and constant by round group
  always_comb begin
    if (rnd_q < 7'd20) begin
      f_rnd = (b_q & c_q) | (~b_q & d_q);
      k_rnd = K_ROUND0;
    end else if (rnd_q < 7'd40) begin
      f_rnd = b_q ^ c_q ^ d_q;
      k_rnd = K_ROUND1;
    end else if (rnd_q < 7'd60) begin
      f_rnd = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_rnd = K_ROUND2;
    end else begin
      f_rnd = b_q ^ c_q ^ d_q;
      k_rnd = K_ROUND3;
    end
  end

  assign t_rnd = {a_q[26:0], a_q[31:27]} + f_rnd + e_q + k_rnd + w_q[0];
  assign w_new = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
                  w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};

  // Control: busy through 80 rounds, then one cycle of final add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 7'd1;
        if (rnd_q == 7'd79) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // Datapath: load, advance one round, fold into chaining value
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      a_q <= chain_i[159:128];
      b_q <= chain_i[127:96];
      c_q <= chain_i[95:64];
      d_q <= chain_i[63:32];
      e_q <= chain_i[31:0];
      for (int i = 0; i < 5; i++) begin
        h_q[i] <= chain_i[DigestW-1-32*i -: 32];
      end
      for (int j = 0; j < 16; j++) begin
        w_q[j] <= block_i[BlockW-1-32*j -: 32];
      end
    end else if (busy_q) begin
      a_q <= t_rnd;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      for (int j = 0; j < 15; j++) begin
        w_q[j] <= w_q[j+1];
      end
      w_q[15] <= w_new;
    end else if (fin_q) begin
      h_q[0] <= h_q[0] + a_q;
      h_q[1] <= h_q[1] + b_q;
      h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q;
      h_q[4] <= h_q[4] + e_q;
    end
  end

  assign rsp_o.done = done_q;
  assign digest_o   = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};

endmodule

### rtl/hotp_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hotp_mod_unit
// Remainder modulo one million by reciprocal multiplication, two steps.
// ----------------------------------------------------------------------------
module hotp_mod_unit import hotp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  unit_req_t         req_i,
  input  logic [TruncW-1:0] value_i,
  output unit_rsp_t         rsp_o,
  output logic [CodeW-1:0]  rem_o
);

  logic              busy_q, step_q, done_q;
  logic [TruncW-1:0] val_q;
  logic [QuoW-1:0]   quo_q;
  logic [CodeW-1:0]  rem_q;
  logic [ProdW-1:0]  prod;
  logic [TruncW-1:0] quo_scaled;
  logic [TruncW-1:0] diff;

  // Quotient: value / 64 times the reciprocal of 15625
  assign prod = ProdW'(val_q[TruncW-1 -: RecipInW]) * ProdW'(RECIP_15625);

  // Remainder: value minus quotient times one million
  assign quo_scaled = TruncW'(quo_q) * HOTP_MODULUS;
  assign diff       = val_q - quo_scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= 1'b0;
      end else if (busy_q) begin
        step_q <= 1'b1;
        if (step_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load the value, then the quotient, then the remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      val_q <= value_i;
    end else if (busy_q && !step_q) begin
      quo_q <= prod[RecipShift +: QuoW];
    end else if (busy_q && step_q) begin
      rem_q <= diff[CodeW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rem_o      = rem_q;

endmodule

### rtl/hotp_code_generator.sv
`timescale 1ns / 1ps
// Sequence: four SHA-1 compressions (load, 80 rounds, final add, done) on
//   one round unit, then truncation and a two-step remainder unit.
// Flow: one counter at a time; the next counter is taken only after the code
//   beat has been accepted on ready.
// Reset: async active low; clears the sequencer and key words to zero.
// ----------------------------------------------------------------------------
// hotp_code_generator
// HMAC-SHA1 over a 64-bit counter, dynamic truncation, six-digit code.
// ----------------------------------------------------------------------------
module hotp_code_generator import hotp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hotp_cfg_if.sink   cfg_i,
  hotp_in_if.sink    in_i,
  hotp_out_if.source out_o
);

  hotp_state_e         state_q, state_d;
  logic [1:0]          blk_q;
  logic [CounterW-1:0] ctr_q;
  logic [DigestW-1:0]  inner_q;
  logic [TruncW-1:0]   trunc_q;
  logic [CodeW-1:0]    code_q;
  logic [63:0]         key_q [KeyWords];

  logic [BlockW-1:0]   key_blk, blk_sel;
  logic [DigestW-1:0]  chain_sel, digest;
  logic [DigestW-1:0]  mac_shift;
  logic [31:0]         trunc_sel;
  logic [31:0]         trunc_msk;
  logic [CodeW-1:0]    rem;
  unit_req_t           sha_req, mod_req;
  unit_rsp_t           sha_rsp, mod_rsp;
  logic                in_fire;

  // Key words; writes beyond the list drop
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeyWords; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_i.valid && !cfg_i.index[CfgIdxW-1]) begin
      key_q[cfg_i.index[CfgIdxW-2:0]] <= cfg_i.data;
    end
  end

  assign key_blk = {key_q[0], key_q[1], key_q[2], key_q[3],
                    key_q[4], key_q[5], key_q[6], key_q[7]};

  // Select block and chaining value for the current compression
  always_comb begin
    case (blk_q)
      BLK_IPAD: begin
        blk_sel   = key_blk ^ {64{IPAD_BYTE}};
        chain_sel = SHA1_IV;
      end
      BLK_INNER: begin
        blk_sel   = {ctr_q, 8'h80, 376'd0, INNER_LEN_BITS};
        chain_sel = digest;
      end
      BLK_OPAD: begin
        blk_sel   = key_blk ^ {64{OPAD_BYTE}};
        chain_sel = SHA1_IV;
      end
      default: begin
        blk_sel   = {inner_q, 8'h80, 280'd0, OUTER_LEN_BITS};
        chain_sel = digest;
      end
    endcase
  end

  hotp_sha1_core u_sha1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (sha_req),
    .chain_i  (chain_sel),
    .block_i  (blk_sel),
    .rsp_o    (sha_rsp),
    .digest_o (digest)
  );

  // Dynamic truncation: four bytes at the offset in the last nibble
  assign mac_shift = digest << {(digest[7:0] & OFFSET_MASK), 3'b000};
  assign trunc_sel = mac_shift[DigestW-1 -: 32];
  assign trunc_msk = {trunc_sel[31:24] & TOP_MASK, trunc_sel[23:0]};

  hotp_mod_unit u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mod_req),
    .value_i (trunc_q),
    .rsp_o   (mod_rsp),
    .rem_o   (rem)
  );

  assign in_fire = in_i.valid && in_i.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_i.valid) state_d = ST_LOAD;
      ST_LOAD:     state_d = ST_HASH;
      ST_HASH: begin
        if (sha_rsp.done) state_d = (blk_q == BLK_OUTER) ? ST_TRUNC : ST_LOAD;
      end
      ST_TRUNC:    state_d = ST_MOD;
      ST_MOD:      state_d = ST_MOD_WAIT;
      ST_MOD_WAIT: if (mod_rsp.done) state_d = ST_OUT;
      ST_OUT:      if (out_o.ready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_i.ready    = (state_q == ST_IDLE);
    sha_req.start = (state_q == ST_LOAD);
    mod_req.start = (state_q == ST_MOD);
    out_o.valid   = (state_q == ST_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      blk_q   <= BLK_IPAD;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        blk_q <= BLK_IPAD;
      end else if (state_q == ST_HASH && sha_rsp.done) begin
        blk_q <= blk_q + 2'd1;
      end
    end
  end

  // Payload: hold counter, inner digest, truncated value and code
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ctr_q <= in_i.moving_counter;
    end
    if (state_q == ST_HASH && sha_rsp.done && blk_q == BLK_INNER) begin
      inner_q <= digest;
    end
    if (state_q == ST_TRUNC) begin
      trunc_q <= trunc_msk[TruncW-1:0];
    end
    if (state_q == ST_MOD_WAIT && mod_rsp.done) begin
      code_q <= rem;
    end
  end

  assign out_o.otp_code        = code_q;
  assign out_o.truncated_value = trunc_q;

endmodule

### rtl/hotp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hotp_checker
// Port-level checks on the code generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hotp_checker import hotp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [CodeW-1:0]  otp_code_i,
  input logic [TruncW-1:0] trunc_i
);

  // Hold a stalled result beat
  `HOTP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(otp_code_i), "result dropped while stalled")

  // Code is the truncated value reduced mod one million
  `HOTP_ASSERT(a_code_mod, out_valid_i |-> ({11'd0, otp_code_i} == trunc_i % HOTP_MODULUS), "code does not match truncated value")

  // No new counter while a result waits
  `HOTP_ASSERT(a_one_item, out_valid_i |-> !in_ready_i, "counter taken while result pending")

  // A counter beat is followed by a busy period
  `HOTP_ASSERT(a_busy_after, in_valid_i && in_ready_i |=> !in_ready_i && !out_valid_i, "no busy period after counter beat")

endmodule

bind hotp_code_generator hotp_checker u_hotp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .otp_code_i  (out_o.otp_code),
  .trunc_i     (out_o.truncated_value)
);
